FILE: src/cbd_pkg.sv
// Package with the shared sizes, codes and pointer helpers of the ring buffer deque.
`timescale 1ns / 1ps

package cbd_pkg;

	// Number of slots in the ring; one slot always stays free, so DEPTH - 1 words fit.
	localparam int DEPTH = 1024;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DATA_W = 32;
	localparam int OCC_W = 10;
	localparam int ACT_W = 2;
	localparam int STAT_W = 2;
	localparam int OUT_TDATA_W = ((DATA_W + OCC_W + 7) / 8) * 8;

	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W:0] DEPTH_EXT = (PTR_W + 1)'(DEPTH);

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_BACK  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
		return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] idx);
		return (idx == '0) ? LAST_SLOT : idx - 1'b1;
	endfunction

	// Stored words between front and back, reduced to the width of the occupancy field.
	function automatic logic [OCC_W-1:0] ring_count(input logic [PTR_W-1:0] front,
			input logic [PTR_W-1:0] back);
		logic [PTR_W:0] diff;
		diff = {1'b0, back} - {1'b0, front};
		if (back < front) begin
			diff = diff + DEPTH_EXT;
		end
		return OCC_W'(diff);
	endfunction

endpackage

FILE: src/circular_buffer_deque.sv
// Double-ended queue kept in a circular buffer memory with front and back pointers.
//
// Usage:
// The slave channel (s_tvalid, s_tready, s_tdata, s_tuser) carries one operation per
// transfer: s_tuser selects push front, push back, pop front or pop back, and s_tdata
// holds the word to push (ignored by pops). The master channel returns exactly one
// result transfer per operation, in order: the popped word (zero unless a pop
// succeeded) and the occupancy after the operation in m_tdata, the status in m_tuser
// (ok, pop on empty, push on full). A full deque holds DEPTH - 1 words.
// The result passes through stage 1 and the output register before it is presented.
// Operations do not overlap: a new one is taken only once the previous one has left
// stage 1. This is set by the single-port slot memory, whose read data is registered;
// the next operation is taken as the previous result leaves the output register,
// so reads never see a write still in flight.
// Reset (arst_n low) empties the deque: both pointers return to zero and no result
// is pending. The slot memory is not cleared; only written slots are ever read.
// When the receiver stalls, the result holds in the output register, and at most
// one further operation is taken only once that result is transferred.
`timescale 1ns / 1ps

module circular_buffer_deque
	import cbd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [DATA_W-1:0]      s_tdata,   // [31:0] data
	input  logic [ACT_W-1:0]       s_tuser,   // [1:0] action
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] value, [41:32] occupancy, rest zero
	output logic [STAT_W-1:0]      m_tuser    // [1:0] status
);

	// Slot memory: one write or one read per cycle, registered read data.
	logic [DATA_W-1:0] slot_mem [DEPTH];
	logic [DATA_W-1:0] rdata_s1;

	// Pointers: front is the first stored word, back is one past the last one.
	logic [PTR_W-1:0] front_q;
	logic [PTR_W-1:0] back_q;

	// Stage 1: operation issued to the memory, waiting for read data.
	logic             pend_s1;
	logic             pop_ok_s1;
	status_t          status_s1;
	logic [OCC_W-1:0] occ_s1;

	// Output register.
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	status_t           out_status_q;
	logic [OCC_W-1:0]  out_occ_q;

	logic             in_xfer;
	action_t          action;
	logic             empty;
	logic             full;
	logic [PTR_W-1:0] front_nx;
	logic [PTR_W-1:0] back_nx;
	logic             mem_we;
	logic             mem_re;
	logic [PTR_W-1:0] mem_addr;
	logic             pop_ok;
	status_t          status_nx;

	// A new operation is taken only when no memory read is outstanding and the
	// output register is free or being emptied in this cycle.
	assign s_tready = !pend_s1 && (!out_valid_q || m_tready);
	assign in_xfer = s_tvalid && s_tready;
	assign action = action_t'(s_tuser);
	assign empty = (front_q == back_q);
	assign full = (ring_next(back_q) == front_q);

	// Decode the operation into pointer moves and one memory access.
	always_comb begin
		front_nx = front_q;
		back_nx = back_q;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = back_q;
		pop_ok = 1'b0;
		status_nx = ST_OK;
		case (action)
			ACT_PUSH_FRONT: begin
				if (full) begin
					status_nx = ST_FULL;
				end else begin
					front_nx = ring_prev(front_q);
					mem_addr = ring_prev(front_q);
					mem_we = 1'b1;
				end
			end
			ACT_PUSH_BACK: begin
				if (full) begin
					status_nx = ST_FULL;
				end else begin
					back_nx = ring_next(back_q);
					mem_addr = back_q;
					mem_we = 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					status_nx = ST_EMPTY;
				end else begin
					front_nx = ring_next(front_q);
					mem_addr = front_q;
					mem_re = 1'b1;
					pop_ok = 1'b1;
				end
			end
			ACT_POP_BACK: begin
				if (empty) begin
					status_nx = ST_EMPTY;
				end else begin
					back_nx = ring_prev(back_q);
					mem_addr = ring_prev(back_q);
					mem_re = 1'b1;
					pop_ok = 1'b1;
				end
			end
			default: begin
				status_nx = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_xfer && mem_we) begin
			slot_mem[mem_addr] <= s_tdata;
		end
		if (in_xfer && mem_re) begin
			rdata_s1 <= slot_mem[mem_addr];
		end
	end

	// Pointers and the stage-1 valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= in_xfer;
			if (in_xfer) begin
				front_q <= front_nx;
				back_q <= back_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pop_ok_s1 <= pop_ok;
			status_s1 <= status_nx;
			occ_s1 <= ring_count(front_nx, back_nx);
		end
	end

	// The output register is always free when stage 1 completes, because an
	// operation is taken only if that register is free or its result leaves in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			out_value_q <= pop_ok_s1 ? rdata_s1 : '0;
			out_status_q <= status_s1;
			out_occ_q <= occ_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = OUT_TDATA_W'({out_occ_q, out_value_q});
	assign m_tuser = out_status_q;

`ifndef NO_ASSERTIONS
	// An accepted operation always occupies stage 1 in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n) in_xfer |=> pend_s1)
		else $error("accepted operation did not reach stage 1");

	// Stage 1 never completes into an occupied output register.
	assert property (@(posedge clk) disable iff (!arst_n) pend_s1 |-> !out_valid_q)
		else $error("stage 1 result would overwrite a pending output");

	// Pointers stay inside the ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		(front_q <= LAST_SLOT) && (back_q <= LAST_SLOT))
		else $error("pointer outside the ring");

	// A pop on an empty deque reports zero value and zero occupancy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_status_q == ST_EMPTY)) |-> ((out_value_q == '0) && (out_occ_q == '0)))
		else $error("empty status with nonzero value or occupancy");
`endif

endmodule

FILE: bench/circular_buffer_deque_tb.sv
// Self-checking testbench for the ring buffer deque: random and directed operations against a predictor.
`timescale 1ns / 1ps

module circular_buffer_deque_tb;
	import cbd_pkg::*;

	localparam int CAPACITY = DEPTH - 1;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_LEN = 150;
	localparam int REPORT_MAX = 10;

	typedef struct {
		action_t          act;
		logic [DATA_W-1:0] word;
	} deque_op_t;

	typedef struct {
		logic [DATA_W-1:0] value;
		status_t           status;
		logic [OCC_W-1:0]  occ;
	} deque_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic [ACT_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [STAT_W-1:0] m_tuser;

	circular_buffer_deque DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Operations waiting to be driven, and results the deque still owes us.
	deque_op_t op_queue[$];
	deque_result_t owed_results[$];

	// Predicted deque contents.
	logic [DATA_W-1:0] slot_model[DEPTH];
	logic [PTR_W-1:0] head_idx = '0;
	logic [PTR_W-1:0] tail_idx = '0;

	int plan_count = 0;
	int ops_total = 0;
	int ops_accepted = 0;
	int results_seen = 0;
	int error_count = 0;
	int full_rejects = 0;
	int empty_rejects = 0;
	int peak_occ = 0;
	int quiet_cycles = 0;
	logic op_taken = 1'b0;

	function automatic logic [PTR_W-1:0] step_fwd(input logic [PTR_W-1:0] idx);
		return PTR_W'((int'(idx) + 1) % DEPTH);
	endfunction

	function automatic logic [PTR_W-1:0] step_back(input logic [PTR_W-1:0] idx);
		return PTR_W'((int'(idx) + DEPTH - 1) % DEPTH);
	endfunction

	// Applies one operation to the predicted deque and returns the result it must produce.
	function automatic deque_result_t apply_deque_op(input deque_op_t op);
		deque_result_t r;
		logic empty;
		logic full;
		int occ;
		r.value = '0;
		r.status = ST_OK;
		empty = (head_idx == tail_idx);
		full = (step_fwd(tail_idx) == head_idx);
		case (op.act)
			ACT_PUSH_FRONT: begin
				if (full) begin
					r.status = ST_FULL;
				end else begin
					head_idx = step_back(head_idx);
					slot_model[head_idx] = op.word;
				end
			end
			ACT_PUSH_BACK: begin
				if (full) begin
					r.status = ST_FULL;
				end else begin
					slot_model[tail_idx] = op.word;
					tail_idx = step_fwd(tail_idx);
				end
			end
			ACT_POP_FRONT: begin
				if (empty) begin
					r.status = ST_EMPTY;
				end else begin
					r.value = slot_model[head_idx];
					head_idx = step_fwd(head_idx);
				end
			end
			default: begin
				if (empty) begin
					r.status = ST_EMPTY;
				end else begin
					tail_idx = step_back(tail_idx);
					r.value = slot_model[tail_idx];
				end
			end
		endcase
		if (r.status == ST_FULL) full_rejects++;
		if (r.status == ST_EMPTY) empty_rejects++;
		occ = (int'(tail_idx) + DEPTH - int'(head_idx)) % DEPTH;
		if (occ > peak_occ) peak_occ = occ;
		r.occ = OCC_W'(occ);
		return r;
	endfunction

	// Mostly random words, with the sign, all-ones and zero extremes mixed in now and then.
	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Queues one operation and tracks how full the deque will be once it is done.
	task automatic queue_op(input action_t act, input logic [DATA_W-1:0] word);
		deque_op_t op;
		op.act = act;
		op.word = word;
		op_queue.push_back(op);
		if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
			if (plan_count < CAPACITY) plan_count++;
		end else if (plan_count > 0) begin
			plan_count--;
		end
	endtask

	task automatic queue_random_op(input int push_pct);
		if ($urandom_range(99) < push_pct) begin
			queue_op($urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, pick_word());
		end else begin
			queue_op($urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT, pick_word());
		end
	endtask

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= REPORT_MAX) $display("ERROR at %0t: %s", $realtime, msg);
	endtask

	// Drives operations and the result ready at the falling edge. The idling mode steps
	// through no idling, a sparse sender, a stalling receiver and light idling on both.
	always @(negedge clk) begin
		int idle_pct;
		int stall_pct;
		deque_op_t op;
		if (arst_n) begin
			case ((ops_accepted / PHASE_LEN) % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 85; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 85; end
				default: begin idle_pct = 6; stall_pct = 6; end
			endcase
			if (!s_tvalid || op_taken) begin
				if (op_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
					op = op_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= op.act;
					s_tdata <= op.word;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Checks results, predicts new ones and watches for a hang, all at the rising edge.
	always @(posedge clk) begin
		deque_result_t want;
		deque_op_t op;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				results_seen++;
				if (owed_results.size() == 0) begin
					flag_error($sformatf("result with nothing expected: value %h status %0d occ %0d",
						m_tdata[DATA_W-1:0], m_tuser, m_tdata[DATA_W+OCC_W-1:DATA_W]));
				end else begin
					want = owed_results.pop_front();
					if (m_tdata[DATA_W-1:0] !== want.value || m_tuser !== want.status
							|| m_tdata[DATA_W+OCC_W-1:DATA_W] !== want.occ) begin
						flag_error($sformatf(
							"result %0d: value %h status %0d occ %0d, expected %h %0d %0d",
							results_seen, m_tdata[DATA_W-1:0], m_tuser,
							m_tdata[DATA_W+OCC_W-1:DATA_W], want.value, want.status, want.occ));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				op.act = action_t'(s_tuser);
				op.word = s_tdata;
				owed_results.push_back(apply_deque_op(op));
				ops_accepted++;
			end
			op_taken <= s_tvalid && s_tready;
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("circular_buffer_deque_tb failed");
				$finish;
			end
		end
	end

	initial begin
		// Directed: both pops on empty, extreme words at both ends, then drain both ways.
		queue_op(ACT_POP_FRONT, 32'hFFFF_FFFF);
		queue_op(ACT_POP_BACK, 32'h1234_5678);
		queue_op(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
		queue_op(ACT_PUSH_BACK, 32'h8000_0000);
		queue_op(ACT_PUSH_FRONT, 32'hFFFF_FFFF);
		queue_op(ACT_PUSH_BACK, 32'h0000_0000);
		queue_op(ACT_PUSH_FRONT, 32'hAAAA_AAAA);
		queue_op(ACT_PUSH_BACK, 32'h5555_5555);
		queue_op(ACT_POP_BACK, 32'hFFFF_FFFF);
		queue_op(ACT_POP_FRONT, '0);
		queue_op(ACT_POP_FRONT, '0);
		queue_op(ACT_POP_BACK, '0);
		queue_op(ACT_POP_FRONT, '0);
		queue_op(ACT_POP_BACK, '0);
		queue_op(ACT_POP_BACK, '0);
		queue_op(ACT_PUSH_BACK, 32'h0F0F_0F0F);
		queue_op(ACT_POP_FRONT, '0);
		queue_op(ACT_POP_FRONT, '0);

		// Random traffic at moderate occupancy.
		repeat (300) queue_random_op(55);
		// Build the deque up with push-heavy traffic, so the pointers wrap around the ring.
		repeat (250) queue_random_op(75);
		// Drain to empty and try a few more pops past the end.
		while (plan_count > 0) queue_random_op(10);
		repeat (4) queue_random_op(0);
		repeat (100) queue_random_op(50);
		ops_total = op_queue.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(ops_accepted == ops_total && owed_results.size() == 0)) @(posedge clk);
		repeat (10) @(posedge clk);

		if (owed_results.size() != 0) flag_error("results still owed at the end of the run");
		$display("Ran %0d operations and checked %0d results; peak occupancy %0d of %0d.",
			ops_accepted, results_seen, peak_occ, CAPACITY);
		$display("Refused %0d pushes on a full deque and %0d pops on an empty one; %0d errors.",
			full_rejects, empty_rejects, error_count);
		if (error_count == 0) begin
			$display("circular_buffer_deque_tb passed");
		end else begin
			$display("circular_buffer_deque_tb failed");
		end
		$finish;
	end

endmodule
